@@ design/bta_pkg.sv @@
// shared types and constants for the block table allocator
// no dependencies; imported by the shift unit and the top level
`default_nettype none

package bta_pkg;

  // field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned SIZE_W   = 20;
  localparam int unsigned OFF_W    = 20;
  localparam int unsigned CNT_W    = 21;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SHIFT_W  = 4;

  // operand width of the shared shifter
  localparam int unsigned OP_W = 21;

  // block shift limits and reset value
  localparam int unsigned        SHIFT_MAX   = 12;
  localparam logic [SHIFT_W-1:0] SHIFT_LO    = 4'd2;
  localparam logic [SHIFT_W-1:0] SHIFT_HI    = 4'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QRUN  = 2'd2,
    ACT_QFREE = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_RD,
    ST_EVAL,
    ST_WRITE,
    ST_ALLOC_END,
    ST_CLR_RUN,
    ST_FREE_END,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

@@ design/bta_shift_unit.sv @@
// shared shifter: right shift for block rounding and indexing,
// left shift with count saturation and offset masking; uses bta_pkg
`default_nettype none

module bta_shift_unit (
  input  wire logic [bta_pkg::OP_W-1:0]    a_i,
  input  wire logic [bta_pkg::SHIFT_W-1:0] sh_i,
  output logic      [bta_pkg::OP_W-1:0]    right_o,
  output logic      [bta_pkg::CNT_W-1:0]   count_o,
  output logic      [bta_pkg::OFF_W-1:0]   offset_o
);
  import bta_pkg::*;

  logic [OP_W+SHIFT_MAX-1:0] wide;

  // bytes to blocks, offset to index
  assign right_o = a_i >> sh_i;

  // blocks to bytes
  assign wide = {SHIFT_MAX'(0), a_i} << sh_i;

  // byte count saturates, byte offset wraps
  assign count_o  = (|wide[OP_W+SHIFT_MAX-1:CNT_W]) ? '1 : wide[CNT_W-1:0];
  assign offset_o = wide[OFF_W-1:0];

endmodule

`default_nettype wire

@@ design/block_table_allocator_core.sv @@
// first-fit block allocator over one table-tracked pool
// uses bta_pkg and bta_shift_unit; holds the allocation table memory
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request beat:
//   action, size in bytes, byte offset. Output channel (out_valid_o /
//   out_stall_i) returns one result beat per request: status, result
//   offset and byte count. cfg_we_i writes the block shift register;
//   the user must write it only while the block is idle, which the block does not enforce.
//   One request is in work at a time; in_stall_o is high while it runs.
//   The table is a memory with registered read, so each visited
//   entry costs a read state (ST_RD) and an evaluate state (ST_EVAL).
//   Allocate time grows with the entries visited and the blocks
//   written, free time with the entries cleared. A run-size query
//   reads one entry; a zero or oversized allocate, a free-bytes
//   query or an offset out of range reads none.
//   After reset a clearing pass writes zero to every table entry, one
//   entry per cycle, before the first request is taken; the block
//   shift resets to 5.
//   A result waits in the output register while out_stall_i is high;
//   the next request is still taken, and its result is held back until
//   the output register is free.
`default_nettype none

module block_table_allocator_core #(
  parameter int unsigned TABLE_BLOCKS = 256
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bta_pkg::SHIFT_W-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [bta_pkg::ACT_W-1:0]      in_action_i,
  input  wire logic [bta_pkg::SIZE_W-1:0]     in_size_bytes_i,
  input  wire logic [bta_pkg::OFF_W-1:0]      in_byte_offset_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [bta_pkg::STATUS_W-1:0]   out_status_o,
  output logic      [bta_pkg::OFF_W-1:0]      out_result_offset_o,
  output logic      [bta_pkg::CNT_W-1:0]      out_byte_count_o
);
  import bta_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_BLOCKS);
  localparam int unsigned EW = $clog2(TABLE_BLOCKS + 1);
  localparam int unsigned PW = IW + 1;

  localparam logic [PW-1:0]   TB_P   = PW'(TABLE_BLOCKS);
  localparam logic [EW-1:0]   TB_E   = EW'(TABLE_BLOCKS);
  localparam logic [OP_W-1:0] TB_OP  = OP_W'(TABLE_BLOCKS);
  localparam logic [IW-1:0]   LAST_I = IW'(TABLE_BLOCKS - 1);

  state_e                state_q, state_d;
  action_e               act_q, act_d;
  logic [SHIFT_W-1:0]    block_shift_q;
  logic [SHIFT_W-1:0]    eff_sh;
  logic [SIZE_W-1:0]     size_q, size_d;
  logic [OFF_W-1:0]      off_q, off_d;
  logic [EW-1:0]         need_q, need_d;
  logic [EW-1:0]         run_q, run_d;
  logic [PW-1:0]         pos_q, pos_d;
  logic [IW-1:0]         wpos_q, wpos_d;
  logic [IW-1:0]         start_q, start_d;
  logic [EW-1:0]         rem_q, rem_d;
  logic [EW-1:0]         len_q, len_d;
  logic [EW-1:0]         free_q, free_d;
  logic [STATUS_W-1:0]   res_status_q, res_status_d;
  logic [OFF_W-1:0]      res_off_q, res_off_d;
  logic [CNT_W-1:0]      res_cnt_q, res_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [OFF_W-1:0]      out_off_q, out_off_d;
  logic [CNT_W-1:0]      out_cnt_q, out_cnt_d;

  // table memory
  logic [EW-1:0]         mem [TABLE_BLOCKS];
  logic [EW-1:0]         rd_q;
  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_waddr, mem_raddr;
  logic [EW-1:0]         mem_wdata;

  // shifter operands
  logic [OP_W-1:0]       sh_a, sh_right, round_mask;
  logic [CNT_W-1:0]      sh_count;
  logic [OFF_W-1:0]      sh_offset;
  logic [PW-1:0]         pos_n;
  logic [EW:0]           free_sum;

  // block shift clamped to the supported range
  always_comb begin
    if (block_shift_q < SHIFT_LO) begin
      eff_sh = SHIFT_LO;
    end else if (block_shift_q > SHIFT_HI) begin
      eff_sh = SHIFT_HI;
    end else begin
      eff_sh = block_shift_q;
    end
  end

  assign round_mask = (OP_W'(1) << eff_sh) - OP_W'(1);

  bta_shift_unit u_shift (
    .a_i      (sh_a),
    .sh_i     (eff_sh),
    .right_o  (sh_right),
    .count_o  (sh_count),
    .offset_o (sh_offset)
  );

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      block_shift_q <= cfg_wdata_i;
    end
  end

  // memory write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // memory read port, registered
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      wpos_q      <= '0;
      free_q      <= TB_E;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wpos_q      <= wpos_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    size_q       <= size_d;
    off_q        <= off_d;
    need_q       <= need_d;
    run_q        <= run_d;
    pos_q        <= pos_d;
    start_q      <= start_d;
    rem_q        <= rem_d;
    len_q        <= len_d;
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_cnt_q    <= res_cnt_d;
    out_status_q <= out_status_d;
    out_off_q    <= out_off_d;
    out_cnt_q    <= out_cnt_d;
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    size_d       = size_q;
    off_d        = off_q;
    need_d       = need_q;
    run_d        = run_q;
    pos_d        = pos_q;
    wpos_d       = wpos_q;
    start_d      = start_q;
    rem_d        = rem_q;
    len_d        = len_q;
    free_d       = free_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_cnt_d    = res_cnt_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;
    out_cnt_d    = out_cnt_q;
    mem_we       = 1'b0;
    mem_waddr    = wpos_q;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = pos_q[IW-1:0];
    sh_a         = '0;
    pos_n        = '0;
    free_sum     = '0;

    // output beat taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (wpos_q == LAST_I) begin
          wpos_d  = '0;
          state_d = ST_IDLE;
        end else begin
          wpos_d = wpos_q + IW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          act_d        = action_e'(in_action_i);
          size_d       = in_size_bytes_i;
          off_d        = in_byte_offset_i;
          res_status_d = STATUS_OK;
          res_off_d    = '0;
          res_cnt_d    = '0;
          state_d      = ST_DECODE;
        end
      end

      ST_DECODE: begin
        unique case (act_q) inside
          ACT_ALLOC: begin
            // round bytes up to whole blocks
            sh_a = OP_W'(size_q) + round_mask;
            if (sh_right == '0 || sh_right > TB_OP) begin
              res_status_d = STATUS_NOFIT;
              state_d      = ST_RESP;
            end else begin
              need_d  = sh_right[EW-1:0];
              pos_d   = '0;
              run_d   = '0;
              state_d = ST_RD;
            end
          end
          ACT_FREE, ACT_QRUN: begin
            sh_a = OP_W'(off_q);
            if (sh_right >= TB_OP) begin
              res_status_d = STATUS_RANGE;
              state_d      = ST_RESP;
            end else begin
              pos_d   = sh_right[PW-1:0];
              state_d = ST_RD;
            end
          end
          default: begin
            sh_a      = OP_W'(free_q);
            res_cnt_d = sh_count;
            state_d   = ST_RESP;
          end
        endcase
      end

      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_EVAL;
      end

      ST_EVAL: begin
        unique case (act_q) inside
          ACT_ALLOC: begin
            if (rd_q == '0) begin
              if (run_q + EW'(1) == need_q) begin
                start_d = IW'(pos_q + PW'(1) - PW'(need_q));
                wpos_d  = IW'(pos_q + PW'(1) - PW'(need_q));
                state_d = ST_WRITE;
              end else begin
                run_d = run_q + EW'(1);
                pos_n = pos_q + PW'(1);
              end
            end else begin
              run_d = '0;
              pos_n = pos_q + PW'(rd_q);
            end
            // walk continues unless the run was found
            if (!(rd_q == '0 && run_q + EW'(1) == need_q)) begin
              if (pos_n >= TB_P) begin
                res_status_d = STATUS_NOFIT;
                state_d      = ST_RESP;
              end else begin
                pos_d   = pos_n;
                state_d = ST_RD;
              end
            end
          end
          ACT_FREE: begin
            len_d   = rd_q;
            rem_d   = rd_q;
            wpos_d  = pos_q[IW-1:0];
            state_d = (rd_q == '0) ? ST_FREE_END : ST_CLR_RUN;
          end
          default: begin
            sh_a      = OP_W'(rd_q);
            res_cnt_d = sh_count;
            state_d   = ST_RESP;
          end
        endcase
      end

      ST_WRITE: begin
        // head holds the run length, the rest hold one
        mem_we    = 1'b1;
        mem_wdata = (wpos_q == start_q) ? need_q : EW'(1);
        if (wpos_q == pos_q[IW-1:0]) begin
          state_d = ST_ALLOC_END;
        end else begin
          wpos_d = wpos_q + IW'(1);
        end
      end

      ST_ALLOC_END: begin
        free_d    = (free_q > need_q) ? free_q - need_q : '0;
        sh_a      = OP_W'(start_q);
        res_off_d = sh_offset;
        state_d   = ST_RESP;
      end

      ST_CLR_RUN: begin
        mem_we = 1'b1;
        rem_d  = rem_q - EW'(1);
        if (rem_q == EW'(1) || wpos_q == LAST_I) begin
          state_d = ST_FREE_END;
        end else begin
          wpos_d = wpos_q + IW'(1);
        end
      end

      ST_FREE_END: begin
        free_sum = {1'b0, free_q} + {1'b0, len_q};
        free_d   = (free_sum > {1'b0, TB_E}) ? TB_E : free_sum[EW-1:0];
        state_d  = ST_RESP;
      end

      ST_RESP: begin
        // hand the result over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_off_d    = res_off_q;
          out_cnt_d    = res_cnt_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_status_q;
  assign out_result_offset_o = out_off_q;
  assign out_byte_count_o    = out_cnt_q;

  // free total never exceeds the pool
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= TB_E)
    else $error("free block count above pool size");

  // failed requests report neither offset nor count
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o != STATUS_OK |->
      out_result_offset_o == '0 && out_byte_count_o == '0)
    else $error("failed result carries offset or count");

  // a result has an offset or a count, never both
  a_off_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_result_offset_o != '0 |-> out_byte_count_o == '0)
    else $error("result carries both offset and count");

  // table writes stay inside the pool
  a_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> PW'(mem_waddr) < TB_P)
    else $error("table write beyond last entry");

  // no request taken until the clearing pass is done
  a_clear_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |=> state_q == ST_CLEAR || state_q == ST_IDLE)
    else $error("clearing pass left early");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking bench for block_table_allocator_core: request traffic, checks on each result beat
// depends on bta_pkg and the block_table_allocator_core rtl; runs stand-alone

module tb_top;
  import bta_pkg::*;

  localparam int unsigned TABLE_BLOCKS   = 256;
  localparam int unsigned COUNT_SAT      = (1 << CNT_W) - 1;
  localparam int unsigned SIZE_MAX       = (1 << SIZE_W) - 1;
  localparam int unsigned WATCHDOG_LIMIT = 20 * TABLE_BLOCKS;
  localparam int unsigned DRAIN_CYCLES   = 3 * TABLE_BLOCKS + 16;
  localparam int unsigned PHASE_BEATS    = 116;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [CNT_W-1:0]    count;
  } reply_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [SHIFT_W-1:0]  cfg_wdata = '0;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic [ACT_W-1:0]    req_action = ACT_QFREE;
  logic [SIZE_W-1:0]   req_size   = '0;
  logic [OFF_W-1:0]    req_offset = '0;
  logic                rsp_valid;
  logic                rsp_stall  = 1'b0;
  logic [STATUS_W-1:0] rsp_status;
  logic [OFF_W-1:0]    rsp_offset;
  logic [CNT_W-1:0]    rsp_count;

  // mirror of the block state
  int unsigned      blk_map [TABLE_BLOCKS] = '{default: 0};
  int unsigned      free_cnt  = TABLE_BLOCKS;
  logic [SHIFT_W-1:0] shift_reg = SHIFT_RESET;

  reply_t      reply_q [$];
  reply_t      last_reply;
  int unsigned live_heads [$];
  int unsigned fail_cnt    = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  block_table_allocator_core #(
    .TABLE_BLOCKS(TABLE_BLOCKS)
  ) dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (req_valid),
    .in_stall_o         (req_stall),
    .in_action_i        (req_action),
    .in_size_bytes_i    (req_size),
    .in_byte_offset_i   (req_offset),
    .out_valid_o        (rsp_valid),
    .out_stall_i        (rsp_stall),
    .out_status_o       (rsp_status),
    .out_result_offset_o(rsp_offset),
    .out_byte_count_o   (rsp_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // block shift as the block uses it, clamped to the legal range
  function automatic int unsigned eff_shift();
    if (shift_reg < SHIFT_LO) return SHIFT_LO;
    if (shift_reg > SHIFT_HI) return SHIFT_HI;
    return shift_reg;
  endfunction

  // block count to bytes, saturating at the count width
  function automatic logic [CNT_W-1:0] blocks_to_bytes(int unsigned blocks, int unsigned sh);
    longint unsigned v;
    v = blocks;
    v = v << sh;
    if (v > COUNT_SAT) v = COUNT_SAT;
    return v[CNT_W-1:0];
  endfunction

  // apply one request to the mirrored table and return the reply it yields
  function automatic reply_t table_reply(action_e act, logic [SIZE_W-1:0] size,
                                         logic [OFF_W-1:0] off);
    reply_t      r;
    int unsigned sh, need, pos, run, idx, len, start, k;
    bit          found;
    r  = '0;
    sh = eff_shift();
    case (act) inside
      ACT_ALLOC: begin
        need  = (size + (32'd1 << sh) - 1) >> sh;
        pos   = 0;
        run   = 0;
        found = 1'b0;
        // first-fit walk, hopping over used runs by the entry value
        if (need != 0) begin
          while (pos < TABLE_BLOCKS && !found) begin
            if (blk_map[pos] == 0) begin
              run++;
              if (run == need) found = 1'b1;
              else pos++;
            end else begin
              run = 0;
              pos += blk_map[pos];
            end
          end
        end
        if (!found) begin
          r.status = STATUS_NOFIT;
        end else begin
          start = pos - (need - 1);
          blk_map[start] = need;
          for (k = start + 1; k <= pos; k++) blk_map[k] = 1;
          free_cnt = (free_cnt > need) ? free_cnt - need : 0;
          r.offset = OFF_W'(start << sh);
        end
      end
      ACT_FREE, ACT_QRUN: begin
        idx = off >> sh;
        if (idx >= TABLE_BLOCKS) begin
          r.status = STATUS_RANGE;
        end else if (act == ACT_QRUN) begin
          r.count = blocks_to_bytes(blk_map[idx], sh);
        end else begin
          len = blk_map[idx];
          for (k = 0; k < len && idx + k < TABLE_BLOCKS; k++) blk_map[idx + k] = 0;
          free_cnt = (free_cnt + len > TABLE_BLOCKS) ? TABLE_BLOCKS : free_cnt + len;
        end
      end
      default: r.count = blocks_to_bytes(free_cnt, sh);
    endcase
    return r;
  endfunction

  // drive one request beat, with random sender gaps ahead of it
  task automatic send_req(action_e act, logic [SIZE_W-1:0] size, logic [OFF_W-1:0] off);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_action <= act;
    req_size   <= size;
    req_offset <= off;
    last_reply = table_reply(act, size, off);
    reply_q.push_back(last_reply);
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // stop sending and wait until every reply is back
  task automatic drain_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
  endtask

  // block shift write, only with the block idle
  task automatic write_block_shift(logic [SHIFT_W-1:0] value);
    drain_replies();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    shift_reg = value;
  endtask

  task automatic set_idling(int unsigned mode);
    case (mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 56; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 56; end
      default: begin send_idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  // one random request, mostly well-formed allocate / free of a live run
  task automatic random_item();
    int unsigned sh, pick, need, idx, j, size32;
    logic [OFF_W-1:0] off;
    sh   = eff_shift();
    pick = $urandom_range(99);
    if (pick < 40) begin
      case ($urandom_range(9))
        0:       need = $urandom_range(TABLE_BLOCKS, 1);
        1, 2:    need = $urandom_range(32, 1);
        default: need = $urandom_range(6, 1);
      endcase
      size32 = ((need - 1) << sh) + $urandom_range(1 << sh, 1);
      if (size32 > SIZE_MAX) size32 = SIZE_MAX;
      send_req(ACT_ALLOC, SIZE_W'(size32), OFF_W'($urandom_range(SIZE_MAX)));
      if (last_reply.status == STATUS_OK) live_heads.push_back(last_reply.offset >> sh);
    end else if (pick < 65 && live_heads.size() != 0) begin
      j   = $urandom_range(live_heads.size() - 1);
      idx = live_heads[j];
      live_heads.delete(j);
      off = OFF_W'((idx << sh) | $urandom_range((1 << sh) - 1));
      send_req(ACT_FREE, SIZE_W'($urandom_range(SIZE_MAX)), off);
    end else if (pick < 75) begin
      if (live_heads.size() != 0 && $urandom_range(1))
        idx = live_heads[$urandom_range(live_heads.size() - 1)];
      else
        idx = $urandom_range(TABLE_BLOCKS - 1);
      off = OFF_W'((idx << sh) | $urandom_range((1 << sh) - 1));
      send_req(ACT_QRUN, SIZE_W'($urandom_range(SIZE_MAX)), off);
    end else if (pick < 83) begin
      send_req(ACT_QFREE, SIZE_W'($urandom_range(SIZE_MAX)),
               OFF_W'($urandom_range(SIZE_MAX)));
    end else begin
      // noise: wild sizes and offsets, zero-byte allocate, stray frees
      case ($urandom_range(4))
        0: send_req(ACT_ALLOC, SIZE_W'($urandom_range(SIZE_MAX)),
                    OFF_W'($urandom_range(SIZE_MAX)));
        1: send_req(ACT_ALLOC, '0, OFF_W'($urandom_range(SIZE_MAX)));
        2: send_req(ACT_FREE, SIZE_W'($urandom_range(SIZE_MAX)),
                    OFF_W'($urandom_range(SIZE_MAX)));
        3: send_req(ACT_FREE, SIZE_W'($urandom_range(SIZE_MAX)),
                    OFF_W'($urandom_range(TABLE_BLOCKS - 1) << sh));
        default: send_req(ACT_QRUN, SIZE_W'($urandom_range(SIZE_MAX)),
                          OFF_W'($urandom_range(SIZE_MAX)));
      endcase
    end
  endtask

  // reset state, field extremes and the awkward table cases at a 32-byte block
  task automatic test_directed_edges();
    set_idling(3);
    send_req(ACT_QFREE, '0, '0);
    send_req(ACT_ALLOC, '0, '0);
    send_req(ACT_ALLOC, 20'd1, '0);
    send_req(ACT_ALLOC, 20'd32, '0);
    send_req(ACT_ALLOC, 20'd33, '0);
    send_req(ACT_QRUN, '0, 20'd64);
    send_req(ACT_QRUN, '0, 20'd101);
    send_req(ACT_QRUN, '0, 20'hFFFFF);
    send_req(ACT_FREE, '0, 20'd8192);
    send_req(ACT_QRUN, '0, 20'd8191);
    send_req(ACT_ALLOC, 20'hFFFFF, '0);
    // fill the rest of the pool, then a full-table walk that fails
    send_req(ACT_ALLOC, 20'd8064, '0);
    send_req(ACT_QFREE, '0, '0);
    send_req(ACT_ALLOC, 20'd1, '0);
    // inner entry of a run, twice, then a hole the walk cannot reach
    send_req(ACT_FREE, '0, 20'd96);
    send_req(ACT_FREE, '0, 20'd96);
    send_req(ACT_ALLOC, 20'd32, '0);
    // head frees that overcount and saturate the free total
    send_req(ACT_FREE, '0, 20'd64);
    send_req(ACT_FREE, '0, 20'd128);
    send_req(ACT_FREE, '0, 20'd0);
    send_req(ACT_FREE, '0, 20'd32);
    send_req(ACT_QFREE, '0, '0);
    // whole pool in one run
    send_req(ACT_ALLOC, 20'd8192, '0);
    send_req(ACT_FREE, '0, '0);
    send_req(ACT_QFREE, 20'hFFFFF, 20'hFFFFF);
  endtask

  // random traffic under a sweep of block shifts and idling patterns
  task automatic test_shift_sweep();
    logic [SHIFT_W-1:0] shifts [8] = '{4'd5, 4'd0, 4'd15, 4'd2, 4'd12, 4'd9, 4'd3, 4'd10};
    for (int p = 0; p < 8; p++) begin
      write_block_shift(shifts[p]);
      set_idling(p % 4);
      repeat (PHASE_BEATS) random_item();
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // compare each result beat with the oldest outstanding reply
  always @(posedge clk) begin
    reply_t want;
    if (rsp_valid && !rsp_stall) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual status %0d offset %0d count %0d",
                 $time, rsp_status, rsp_offset, rsp_count);
        fail_cnt++;
      end else begin
        want = reply_q.pop_front();
        check_field("status", want.status, rsp_status);
        check_field("result_offset", want.offset, rsp_offset);
        check_field("byte_count", want.count, rsp_count);
      end
    end
  end

  // watchdog on cycles with no beat moving on either channel
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** block_table_allocator_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_edges();
    test_shift_sweep();
    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && reply_q.size() == 0)
      $display("** block_table_allocator_core: PASSED **");
    else
      $display("** block_table_allocator_core: FAILED **");
    $finish;
  end

endmodule
